// ===== sv/cgvs_pkg.sv =====
// shared types and constants of the central gravity verlet step block
package cgvs_pkg;

    // operation codes of a particle request
    typedef enum logic [1:0] {
        OP_STEP   = 2'd0,
        OP_ACCEL  = 2'd1,
        OP_ENERGY = 2'd2,
        OP_RSVD   = 2'd3
    } op_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_CENTER_Z = 2'd2,
        REG_GRAV     = 2'd3
    } reg_idx_t;

    typedef logic signed [31:0] q16_t;

    localparam q16_t Q16Max = 32'sh7fff_ffff;
    localparam q16_t Q16Min = 32'sh8000_0000;

    // square root pipeline: 66-bit radicand, 33-bit root
    localparam int SqSteps = 33;
    localparam int SqInW   = 66;
    localparam int RootW   = 33;
    localparam int SqRemW  = RootW + 2;

    // divider pipeline: 63-bit dividend, 64-bit divisor, one quotient bit a stage
    localparam int DivDw    = 63;
    localparam int DivVw    = 64;
    localparam int DivLanes = 5;

    // divider lane assignment
    localparam int LaneG = 0;
    localparam int LaneU = 1;
    localparam int LaneQ = 4;

    typedef logic [DivDw-1:0] div_dvd_t;
    typedef logic [DivVw-1:0] div_dsr_t;

    // payload that rides along the square root pipeline
    typedef struct packed {
        op_t              op;
        logic [2:0][31:0] new_pos;
        logic [2:0][33:0] va;
        logic [2:0]       d_pos;
        logic [2:0]       d_neg;
        logic [2:0][32:0] dmag;
        logic [61:0]      gm;
    } sqsb_t;

    // payload that rides along the divider pipeline
    typedef struct packed {
        op_t              op;
        logic [2:0][31:0] new_pos;
        logic [2:0][33:0] va;
        logic [2:0]       d_pos;
        logic [2:0]       d_neg;
        logic             r_zero;
        logic             r_big;
    } divsb_t;

endpackage

// ===== sv/cgvs_if.sv =====
// request and result channel interfaces of the central gravity verlet step block
interface cgvs_particle_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
    logic [30:0]        mass;

    modport source (
        output valid, operation, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
        output acc_x, acc_y, acc_z, mass,
        input  ready
    );
    modport sink (
        input  valid, operation, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
        input  acc_x, acc_y, acc_z, mass,
        output ready
    );
endinterface

interface cgvs_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic signed [31:0] new_acc_x;
    logic signed [31:0] new_acc_y;
    logic signed [31:0] new_acc_z;
    logic signed [31:0] potential;

    modport source (
        output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
        output new_vel_z, new_acc_x, new_acc_y, new_acc_z, potential,
        input  ready
    );
    modport sink (
        input  valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
        input  new_vel_z, new_acc_x, new_acc_y, new_acc_z, potential,
        output ready
    );
endinterface

// ===== sv/central_gravity_verlet_step.sv =====
// Central gravity velocity-Verlet unit, top level.
// Takes one particle request per clock and returns one result per request, in order,
// passing through three entry stages (offset, squares, radius sum), a
// 33-stage square root, one stage forming r*r, a 63-stage five-lane divider (gravity
// over r^2, three direction components, energy over r) and three output stages. Every
// stage holds while the output register keeps a result that is not taken, so requests
// are accepted whenever the result register is empty or being read. Configuration
// writes take effect on the next request and are expected only while the pipeline is empty.
module central_gravity_verlet_step (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  cgvs_pkg::reg_idx_t   wr_index,
    input  logic [31:0]          wr_data,
    cgvs_particle_if.sink        particle,
    cgvs_result_if.source        result
);
    import cgvs_pkg::*;

    // round half down of a 35-bit sum and saturate to Q16.16
    function automatic q16_t sat_half(input logic signed [34:0] x);
        logic signed [33:0] h;
        h = x[34:1];
        if ((h[33:31] == 3'b000) || (h[33:31] == 3'b111))
        begin
            return h[31:0];
        end
        return h[33] ? Q16Min : Q16Max;
    endfunction

    // configuration registers
    q16_t        center_reg [3];
    logic [30:0] gp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg[0] <= '0;
            center_reg[1] <= '0;
            center_reg[2] <= '0;
            gp_reg        <= 31'd65536;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_CENTER_X: center_reg[0] <= wr_data;
                REG_CENTER_Y: center_reg[1] <= wr_data;
                REG_CENTER_Z: center_reg[2] <= wr_data;
                REG_GRAV:     gp_reg        <= wr_data[30:0];
                default:      ;
            endcase
        end
    end

    // global advance: the whole pipe moves unless the result register is blocked
    logic adv;
    logic g_valid_reg;

    assign adv            = !g_valid_reg || result.ready;
    assign particle.ready = adv;

    // request fields as axis arrays
    q16_t p_in [3];
    q16_t v_in [3];
    q16_t a_in [3];

    assign p_in[0] = particle.pos_x;
    assign p_in[1] = particle.pos_y;
    assign p_in[2] = particle.pos_z;
    assign v_in[0] = particle.vel_x;
    assign v_in[1] = particle.vel_y;
    assign v_in[2] = particle.vel_z;
    assign a_in[0] = particle.acc_x;
    assign a_in[1] = particle.acc_y;
    assign a_in[2] = particle.acc_z;

    // stage a: offset from centre, new position, 2v + a
    logic               a_valid_reg;
    op_t                a_op_reg;
    logic signed [32:0] a_d_reg   [3];
    logic signed [32:0] a_d_next  [3];
    q16_t               a_pos_reg [3];
    q16_t               a_pos_next[3];
    logic signed [33:0] a_va_reg  [3];
    logic signed [33:0] a_va_next [3];
    logic [30:0]        a_mass_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_d_next[i]   = {p_in[i][31], p_in[i]} - {center_reg[i][31], center_reg[i]};
            a_pos_next[i] = sat_half({{2{p_in[i][31]}}, p_in[i], 1'b0}
                                   + {{2{v_in[i][31]}}, v_in[i], 1'b0}
                                   + {{3{a_in[i][31]}}, a_in[i]});
            a_va_next[i]  = {v_in[i][31], v_in[i], 1'b0} + {{2{a_in[i][31]}}, a_in[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= particle.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_op_reg   <= op_t'(particle.operation);
            a_mass_reg <= particle.mass;
            for (int i = 0; i < 3; i++)
            begin
                a_d_reg[i]   <= a_d_next[i];
                a_pos_reg[i] <= a_pos_next[i];
                a_va_reg[i]  <= a_va_next[i];
            end
        end
    end

    // stage b: squares, magnitudes, signs, gm * mass
    logic               b_valid_reg;
    op_t                b_op_reg;
    logic [64:0]        b_sq_reg   [3];
    logic [32:0]        b_dmag_reg [3];
    logic [2:0]         b_dpos_reg;
    logic [2:0]         b_dneg_reg;
    q16_t               b_pos_reg  [3];
    logic signed [33:0] b_va_reg   [3];
    logic [61:0]        b_gm_reg;
    logic signed [65:0] b_sq_full  [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            b_sq_full[i] = a_d_reg[i] * a_d_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_op_reg <= a_op_reg;
            b_gm_reg <= gp_reg * a_mass_reg;
            for (int i = 0; i < 3; i++)
            begin
                b_sq_reg[i]   <= b_sq_full[i][64:0];
                b_dmag_reg[i] <= a_d_reg[i][32] ? 33'(-a_d_reg[i]) : a_d_reg[i];
                b_dpos_reg[i] <= !a_d_reg[i][32] && (a_d_reg[i] != '0);
                b_dneg_reg[i] <= a_d_reg[i][32];
                b_pos_reg[i]  <= a_pos_reg[i];
                b_va_reg[i]   <= a_va_reg[i];
            end
        end
    end

    // stage c: squared radius and the payload for the root pipeline
    logic             c_valid_reg;
    logic [SqInW-1:0] c_s_reg;
    sqsb_t            c_sb_reg;
    sqsb_t            c_sb_next;

    always_comb
    begin
        c_sb_next.op = b_op_reg;
        c_sb_next.gm = b_gm_reg;
        for (int i = 0; i < 3; i++)
        begin
            c_sb_next.new_pos[i] = b_pos_reg[i];
            c_sb_next.va[i]      = b_va_reg[i];
            c_sb_next.d_pos[i]   = b_dpos_reg[i];
            c_sb_next.d_neg[i]   = b_dneg_reg[i];
            c_sb_next.dmag[i]    = b_dmag_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_s_reg  <= {1'b0, b_sq_reg[0]} + {1'b0, b_sq_reg[1]} + {1'b0, b_sq_reg[2]};
            c_sb_reg <= c_sb_next;
        end
    end

    // radius
    logic             sq_valid;
    logic [RootW-1:0] sq_root;
    sqsb_t            sq_sb;

    cgvs_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (c_valid_reg),
        .in_s      (c_s_reg),
        .in_sb     (c_sb_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_sb    (sq_sb)
    );

    // stage r: r squared and the divider operands
    logic     r_valid_reg;
    div_dvd_t r_dvd_reg [DivLanes];
    div_dsr_t r_dsr_reg [DivLanes];
    divsb_t   r_sb_reg;
    divsb_t   r_sb_next;

    always_comb
    begin
        r_sb_next.op      = sq_sb.op;
        r_sb_next.new_pos = sq_sb.new_pos;
        r_sb_next.va      = sq_sb.va;
        r_sb_next.d_pos   = sq_sb.d_pos;
        r_sb_next.d_neg   = sq_sb.d_neg;
        r_sb_next.r_zero  = (sq_root == '0);
        r_sb_next.r_big   = sq_root[RootW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            r_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_sb_reg         <= r_sb_next;
            r_dvd_reg[LaneG] <= {gp_reg, 32'd0};
            r_dsr_reg[LaneG] <= sq_root[31:0] * sq_root[31:0];
            for (int i = 0; i < 3; i++)
            begin
                r_dvd_reg[LaneU+i] <= DivDw'({sq_sb.dmag[i], 16'd0});
                r_dsr_reg[LaneU+i] <= DivVw'(sq_root);
            end
            r_dvd_reg[LaneQ] <= DivDw'(sq_sb.gm);
            r_dsr_reg[LaneQ] <= DivVw'(sq_root);
        end
    end

    // quotients
    logic     dv_valid;
    div_dvd_t dv_quo [DivLanes];
    divsb_t   dv_sb;

    cgvs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (r_valid_reg),
        .dividend  (r_dvd_reg),
        .divisor   (r_dsr_reg),
        .in_sb     (r_sb_reg),
        .out_valid (dv_valid),
        .quotient  (dv_quo),
        .out_sb    (dv_sb)
    );

    // stage e: clamp gravity over r^2, direction components, energy
    logic        e_valid_reg;
    logic [47:0] e_g_reg;
    logic [47:0] e_g_next;
    logic [16:0] e_u_reg [3];
    q16_t        e_pot_reg;
    q16_t        e_pot_next;
    divsb_t      e_sb_reg;
    div_dvd_t    g_raw;
    div_dvd_t    q_raw;

    always_comb
    begin
        g_raw = dv_quo[LaneG];
        q_raw = dv_quo[LaneQ];
        if (dv_sb.r_zero || dv_sb.r_big)
        begin
            e_g_next = '0;
        end
        else if ((|g_raw[DivDw-1:48]) || (g_raw[47] && (|g_raw[46:0])))
        begin
            e_g_next = 48'h8000_0000_0000;
        end
        else
        begin
            e_g_next = g_raw[47:0];
        end
        if (dv_sb.r_zero || (|q_raw[DivDw-1:31]))
        begin
            e_pot_next = Q16Min;
        end
        else
        begin
            e_pot_next = 32'(33'sd0 - $signed({2'b00, q_raw[30:0]}));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            e_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_g_reg   <= e_g_next;
            e_pot_reg <= e_pot_next;
            e_sb_reg  <= dv_sb;
            for (int i = 0; i < 3; i++)
            begin
                e_u_reg[i] <= dv_quo[LaneU+i][16:0];
            end
        end
    end

    // stage f: acceleration magnitude per axis
    logic        f_valid_reg;
    logic [47:0] f_prod_reg [3];
    logic [64:0] f_prod_full[3];
    q16_t        f_pot_reg;
    divsb_t      f_sb_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            f_prod_full[i] = e_g_reg * e_u_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_pot_reg <= e_pot_reg;
            f_sb_reg  <= e_sb_reg;
            for (int i = 0; i < 3; i++)
            begin
                f_prod_reg[i] <= f_prod_full[i][63:16];
            end
        end
    end

    // stage g: signed acceleration, new velocity, result selection
    q16_t acc     [3];
    q16_t vel     [3];
    q16_t g_pos_next [3];
    q16_t g_vel_next [3];
    q16_t g_acc_next [3];
    q16_t g_pot_next;
    q16_t g_pos_reg  [3];
    q16_t g_vel_reg  [3];
    q16_t g_acc_reg  [3];
    q16_t g_pot_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (f_sb_reg.d_pos[i])
            begin
                acc[i] = (|f_prod_reg[i][47:31]) ? Q16Min
                       : 32'(33'sd0 - $signed({2'b00, f_prod_reg[i][30:0]}));
            end
            else if (f_sb_reg.d_neg[i])
            begin
                acc[i] = (|f_prod_reg[i][47:31]) ? Q16Max : {1'b0, f_prod_reg[i][30:0]};
            end
            else
            begin
                acc[i] = '0;
            end
            vel[i] = sat_half({f_sb_reg.va[i][33], f_sb_reg.va[i]}
                            + {{3{acc[i][31]}}, acc[i]});
        end
        for (int i = 0; i < 3; i++)
        begin
            g_pos_next[i] = '0;
            g_vel_next[i] = '0;
            g_acc_next[i] = '0;
        end
        g_pot_next = '0;
        case (f_sb_reg.op)
            OP_STEP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    g_pos_next[i] = f_sb_reg.new_pos[i];
                    g_vel_next[i] = vel[i];
                    g_acc_next[i] = acc[i];
                end
            end
            OP_ACCEL:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    g_acc_next[i] = acc[i];
                end
            end
            OP_ENERGY:
            begin
                g_pot_next = f_pot_reg;
            end
            default:
            begin
                g_pot_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            g_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g_pot_reg <= g_pot_next;
            for (int i = 0; i < 3; i++)
            begin
                g_pos_reg[i] <= g_pos_next[i];
                g_vel_reg[i] <= g_vel_next[i];
                g_acc_reg[i] <= g_acc_next[i];
            end
        end
    end

    // result channel
    assign result.valid     = g_valid_reg;
    assign result.new_pos_x = g_pos_reg[0];
    assign result.new_pos_y = g_pos_reg[1];
    assign result.new_pos_z = g_pos_reg[2];
    assign result.new_vel_x = g_vel_reg[0];
    assign result.new_vel_y = g_vel_reg[1];
    assign result.new_vel_z = g_vel_reg[2];
    assign result.new_acc_x = g_acc_reg[0];
    assign result.new_acc_y = g_acc_reg[1];
    assign result.new_acc_z = g_acc_reg[2];
    assign result.potential = g_pot_reg;

endmodule

// ===== sv/cgvs_sqrt.sv =====
// pipelined integer square root, one root bit per stage
module cgvs_sqrt (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [cgvs_pkg::SqInW-1:0] in_s,
    input  cgvs_pkg::sqsb_t           in_sb,
    output logic                      out_valid,
    output logic [cgvs_pkg::RootW-1:0] out_root,
    output cgvs_pkg::sqsb_t           out_sb
);
    import cgvs_pkg::*;

    logic              valid_reg [SqSteps];
    logic [SqRemW-1:0] rem_reg   [SqSteps];
    logic [RootW-1:0]  root_reg  [SqSteps];
    logic [SqInW-1:0]  s_reg     [SqSteps];
    sqsb_t             sb_reg    [SqSteps];

    for (genvar k = 0; k < SqSteps; k++)
    begin : g_step
        logic              src_valid;
        logic [SqRemW-1:0] src_rem;
        logic [RootW-1:0]  src_root;
        logic [SqInW-1:0]  src_s;
        sqsb_t             src_sb;
        logic [SqRemW-1:0] rem_try;
        logic [SqRemW-1:0] trial;
        logic [SqRemW-1:0] rem_next;
        logic [RootW-1:0]  root_next;
        logic              fits;

        // stage source: pipeline input or previous stage
        if (k == 0)
        begin : g_head
            assign src_valid = in_valid;
            assign src_rem   = '0;
            assign src_root  = '0;
            assign src_s     = in_s;
            assign src_sb    = in_sb;
        end
        else
        begin : g_body
            assign src_valid = valid_reg[k-1];
            assign src_rem   = rem_reg[k-1];
            assign src_root  = root_reg[k-1];
            assign src_s     = s_reg[k-1];
            assign src_sb    = sb_reg[k-1];
        end

        // bring down two radicand bits and try the next root bit
        always_comb
        begin
            rem_try   = {src_rem[SqRemW-3:0], src_s[SqInW-1 -: 2]};
            trial     = {src_root, 2'b01};
            fits      = (rem_try >= trial);
            rem_next  = fits ? (rem_try - trial) : rem_try;
            root_next = {src_root[RootW-2:0], fits};
        end

        // valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= src_valid;
            end
        end

        // stage data
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                s_reg[k]    <= {src_s[SqInW-3:0], 2'b00};
                sb_reg[k]   <= src_sb;
            end
        end
    end

    assign out_valid = valid_reg[SqSteps-1];
    assign out_root  = root_reg[SqSteps-1];
    assign out_sb    = sb_reg[SqSteps-1];

endmodule

// ===== sv/cgvs_div.sv =====
// pipelined restoring divider, several lanes side by side, one quotient bit per stage
module cgvs_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  cgvs_pkg::div_dvd_t dividend [cgvs_pkg::DivLanes],
    input  cgvs_pkg::div_dsr_t divisor  [cgvs_pkg::DivLanes],
    input  cgvs_pkg::divsb_t   in_sb,
    output logic               out_valid,
    output cgvs_pkg::div_dvd_t quotient [cgvs_pkg::DivLanes],
    output cgvs_pkg::divsb_t   out_sb
);
    import cgvs_pkg::*;

    logic     valid_reg [DivDw];
    div_dsr_t rem_reg   [DivDw][DivLanes];
    div_dvd_t dq_reg    [DivDw][DivLanes];
    div_dsr_t dsr_reg   [DivDw][DivLanes];
    divsb_t   sb_reg    [DivDw];

    for (genvar k = 0; k < DivDw; k++)
    begin : g_step
        logic           src_valid;
        div_dsr_t       src_rem  [DivLanes];
        div_dvd_t       src_dq   [DivLanes];
        div_dsr_t       src_dsr  [DivLanes];
        divsb_t         src_sb;
        logic [DivVw:0] rem_try  [DivLanes];
        logic [DivVw:0] diff     [DivLanes];
        logic           fits     [DivLanes];
        div_dsr_t       rem_next [DivLanes];
        div_dvd_t       dq_next  [DivLanes];

        // stage source: pipeline input or previous stage
        if (k == 0)
        begin : g_head
            assign src_valid = in_valid;
            assign src_sb    = in_sb;
            for (genvar l = 0; l < DivLanes; l++)
            begin : g_lane
                assign src_rem[l] = '0;
                assign src_dq[l]  = dividend[l];
                assign src_dsr[l] = divisor[l];
            end
        end
        else
        begin : g_body
            assign src_valid = valid_reg[k-1];
            assign src_sb    = sb_reg[k-1];
            for (genvar l = 0; l < DivLanes; l++)
            begin : g_lane
                assign src_rem[l] = rem_reg[k-1][l];
                assign src_dq[l]  = dq_reg[k-1][l];
                assign src_dsr[l] = dsr_reg[k-1][l];
            end
        end

        // shift in the next dividend bit, subtract when the divisor fits
        always_comb
        begin
            for (int l = 0; l < DivLanes; l++)
            begin
                rem_try[l]  = {src_rem[l], src_dq[l][DivDw-1]};
                diff[l]     = rem_try[l] - {1'b0, src_dsr[l]};
                fits[l]     = (rem_try[l] >= {1'b0, src_dsr[l]});
                rem_next[l] = fits[l] ? diff[l][DivVw-1:0] : rem_try[l][DivVw-1:0];
                dq_next[l]  = {src_dq[l][DivDw-2:0], fits[l]};
            end
        end

        // valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= src_valid;
            end
        end

        // stage data
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sb_reg[k] <= src_sb;
                for (int l = 0; l < DivLanes; l++)
                begin
                    rem_reg[k][l] <= rem_next[l];
                    dq_reg[k][l]  <= dq_next[l];
                    dsr_reg[k][l] <= src_dsr[l];
                end
            end
        end
    end

    assign out_valid = valid_reg[DivDw-1];
    assign out_sb    = sb_reg[DivDw-1];
    for (genvar l = 0; l < DivLanes; l++)
    begin : g_out
        assign quotient[l] = dq_reg[DivDw-1][l];
    end

endmodule
